FILE: rtl/tsr_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the Taylor sine pipeline.
// No dependencies.
package tsr_pkg;

    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 32;
    localparam int MAG_W   = 31;
    localparam int X2_W    = 34;
    localparam int T_W     = 33;
    localparam int M_W     = 31;
    localparam int SUM_W   = 36;
    localparam int RECIP_W = 30;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 32'd1686629713;
    localparam logic signed [SUM_W-1:0] SINE_ONE = 36'sd1073741824;

    typedef struct packed {
        logic [X2_W-1:0]         x2;
        logic [T_W-1:0]          t;
        logic signed [SUM_W-1:0] sum;
        logic                    term_neg;
    } tsr_item_t;

endpackage

FILE: rtl/tsr_angle_if.sv
`timescale 1ns / 1ps
// Input channel carrying one angle item, Q3.29 radians.
// Depends on tsr_pkg.
interface tsr_angle_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsr_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

FILE: rtl/tsr_sine_if.sv
`timescale 1ns / 1ps
// Output channel carrying one sine item, Q1.30.
// Depends on tsr_pkg.
interface tsr_sine_if;
    logic                               valid;
    logic                               ready;
    logic signed [tsr_pkg::SINE_W-1:0] sine;

    modport source (output valid, output sine, input ready);
    modport sink (input valid, input sine, output ready);
endinterface

FILE: rtl/taylor_sine_term_recurrence.sv
`timescale 1ns / 1ps
// Sine of a Q3.29 angle by a Maclaurin series, result in Q1.30.
// Depends on tsr_pkg, tsr_angle_if, tsr_sine_if, tsr_front, tsr_cell, tsr_tail.
//
// Takes one angle every clock cycle when the output side does not stall. Angles beyond
// plus or minus pi are clamped to pi first; the result saturates to plus or minus 1.0.
// The pipeline is the chain of TERMS series cells, two registered multiplier stages
// each, behind a two-stage squaring front end and one output register. Every stage
// holds its own valid bit, so bubbles collapse and the block keeps taking items while
// a result waits at the output.
module taylor_sine_term_recurrence #(
    parameter int TERMS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    tsr_angle_if.sink       operand,
    tsr_sine_if.source      result
);

    logic               link_valid [TERMS+1];
    logic               link_ready [TERMS+1];
    tsr_pkg::tsr_item_t link_item  [TERMS+1];

    tsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .angle     (operand.angle),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_item  (link_item[0])
    );

    for (genvar i = 0; i < TERMS; i++)
    begin : g_cell
        tsr_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_item   (link_item[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_item  (link_item[i+1])
        );
    end

    tsr_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[TERMS]),
        .in_ready  (link_ready[TERMS]),
        .in_item   (link_item[TERMS]),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sine      (result.sine)
    );

endmodule

FILE: rtl/tsr_front.sv
`timescale 1ns / 1ps
// Head of the chain: takes magnitude and sign, clamps to pi, squares the angle.
// Depends on tsr_pkg.
module tsr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tsr_pkg::ANGLE_W-1:0] angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tsr_pkg::tsr_item_t                  out_item
);

    logic                        a_valid_reg;
    logic                        a_neg_reg;
    logic [tsr_pkg::MAG_W-1:0]   a_mag_reg;
    logic                        a_ready;
    logic                        b_valid_reg;
    tsr_pkg::tsr_item_t          b_item_reg;
    logic                        b_ready;

    logic                        neg_next;
    logic [tsr_pkg::ANGLE_W-1:0] abs_val;
    logic [tsr_pkg::MAG_W-1:0]   mag_next;
    logic [61:0]                 sq_prod;
    logic [61:0]                 sq_round;
    logic [tsr_pkg::T_W-1:0]     x_val;
    tsr_pkg::tsr_item_t          item_next;

    assign neg_next = angle[tsr_pkg::ANGLE_W-1];
    assign abs_val  = neg_next ? (~angle + 32'd1) : angle;
    assign mag_next = (abs_val > tsr_pkg::ANGLE_LIMIT)
                    ? tsr_pkg::ANGLE_LIMIT[tsr_pkg::MAG_W-1:0]
                    : abs_val[tsr_pkg::MAG_W-1:0];

    assign sq_prod  = 62'(a_mag_reg) * 62'(a_mag_reg);
    assign sq_round = sq_prod + (62'd1 << 27);
    assign x_val    = {1'b0, a_mag_reg, 1'b0};

    always_comb
    begin
        item_next.x2       = sq_round[61:28];
        item_next.t        = x_val;
        item_next.sum      = a_neg_reg ? -$signed(36'(x_val)) : $signed(36'(x_val));
        item_next.term_neg = a_neg_reg;
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_neg_reg <= neg_next;
            a_mag_reg <= mag_next;
        end
        if (b_ready && a_valid_reg)
            b_item_reg <= item_next;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

FILE: rtl/tsr_cell.sv
`timescale 1ns / 1ps
// One series update: scale x squared by a reciprocal, multiply into the term, add or subtract it.
// Depends on tsr_pkg.
module tsr_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsr_pkg::tsr_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tsr_pkg::tsr_item_t out_item
);

    localparam longint unsigned DIVISOR = longint'((2 * IDX + 2) * (2 * IDX + 3));
    localparam longint unsigned RECIP   = ((64'd1 << 32) + DIVISOR / 2) / DIVISOR;
    localparam logic [tsr_pkg::RECIP_W-1:0] RECIP_C = RECIP[tsr_pkg::RECIP_W-1:0];

    logic                      s1_valid_reg;
    tsr_pkg::tsr_item_t        s1_item_reg;
    logic [tsr_pkg::M_W-1:0]   s1_m_reg;
    logic                      s1_ready;
    logic                      s2_valid_reg;
    tsr_pkg::tsr_item_t        s2_item_reg;
    logic                      s2_ready;

    logic [63:0]               m_prod;
    logic [63:0]               m_round;
    logic [tsr_pkg::M_W-1:0]   m_next;
    logic [63:0]               t_prod;
    logic [63:0]               t_round;
    logic [tsr_pkg::T_W-1:0]   t_next;
    logic signed [tsr_pkg::SUM_W-1:0] t_ext;
    tsr_pkg::tsr_item_t        item_next;

    assign m_prod  = 64'(in_item.x2) * 64'(RECIP_C);
    assign m_round = m_prod + (64'd1 << 31);
    assign m_next  = m_round[62:32];

    assign t_prod  = 64'(s1_item_reg.t) * 64'(s1_m_reg);
    assign t_round = t_prod + (64'd1 << 29);
    assign t_next  = t_round[62:30];
    assign t_ext   = $signed(36'(t_next));

    always_comb
    begin
        item_next.x2       = s1_item_reg.x2;
        item_next.t        = t_next;
        item_next.term_neg = !s1_item_reg.term_neg;
        item_next.sum      = item_next.term_neg ? (s1_item_reg.sum - t_ext)
                                                : (s1_item_reg.sum + t_ext);
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg <= in_item;
            s1_m_reg    <= m_next;
        end
        if (s2_ready && s1_valid_reg)
            s2_item_reg <= item_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

FILE: rtl/tsr_tail.sv
`timescale 1ns / 1ps
// End of the chain: saturates the sum to plus or minus one and holds the output item.
// Depends on tsr_pkg.
module tsr_tail (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tsr_pkg::tsr_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tsr_pkg::SINE_W-1:0] sine
);

    logic                               valid_reg;
    logic signed [tsr_pkg::SINE_W-1:0] sine_reg;
    logic signed [tsr_pkg::SINE_W-1:0] sine_next;

    always_comb
    begin
        priority if (in_item.sum > tsr_pkg::SINE_ONE)
            sine_next = tsr_pkg::SINE_ONE[tsr_pkg::SINE_W-1:0];
        else if (in_item.sum < -tsr_pkg::SINE_ONE)
            sine_next = -tsr_pkg::SINE_ONE[tsr_pkg::SINE_W-1:0];
        else
            sine_next = in_item.sum[tsr_pkg::SINE_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sine_reg <= sine_next;
    end

    assign out_valid = valid_reg;
    assign sine      = sine_reg;

endmodule

FILE: verif/tb_taylor_sine_term_recurrence.sv
`timescale 1ns / 1ps
// Testbench for taylor_sine_term_recurrence: directed and random angles, each result
// checked against a bit-exact series predictor, with random input bursts and output stalls.
// Depends on tsr_pkg, tsr_angle_if, tsr_sine_if and the taylor_sine_term_recurrence RTL.
module tb_taylor_sine_term_recurrence;

    localparam int          SERIES_TERMS = 10;
    localparam int          PIPE_LATENCY = 2 * SERIES_TERMS + 3;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [31:0] PI_Q29       = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29  = 32'd843314857;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

    logic clk;
    logic rst_n;

    tsr_angle_if operand_ch ();
    tsr_sine_if  result_ch ();

    taylor_sine_term_recurrence #(
        .TERMS(SERIES_TERMS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .operand(operand_ch),
        .result (result_ch)
    );

    logic signed [tsr_pkg::SINE_W-1:0] expected_sines[$];
    int error_count;
    int cycle_count;
    int burst_left;
    int stall_mode;
    int stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fixed-point Maclaurin sum, magnitude and sign kept apart.
    function automatic logic signed [31:0] sine_series(input logic [31:0] raw);
        logic               neg;
        logic               term_neg;
        logic [63:0]        mag;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        m;
        logic [63:0]        d;
        logic [63:0]        recip;
        logic signed [63:0] sum;
        neg = raw[31];
        mag = neg ? ((64'd1 << 32) - {32'd0, raw}) : {32'd0, raw};
        if (mag > {32'd0, PI_Q29})
            mag = {32'd0, PI_Q29};
        x = mag << 1;
        x2 = (mag * mag + (64'd1 << 27)) >> 28;
        t = x;
        sum = neg ? -$signed(x) : $signed(x);
        term_neg = neg;
        for (int i = 0; i < SERIES_TERMS; i++)
        begin
            d = (64'(2 * i + 2)) * (64'(2 * i + 3));
            recip = ((64'd1 << 32) + d / 2) / d;
            m = (x2 * recip + (64'd1 << 31)) >> 32;
            t = (t * m + (64'd1 << 29)) >> 30;
            term_neg = ~term_neg;
            if (term_neg)
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        if (sum > $signed(ONE_Q30))
            sum = $signed(ONE_Q30);
        if (sum < -$signed(ONE_Q30))
            sum = -$signed(ONE_Q30);
        return sum[31:0];
    endfunction

    // Hold the item until accepted; open a new burst after a random gap.
    task automatic send_angle(input logic [31:0] a);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                operand_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        operand_ch.valid <= 1'b1;
        operand_ch.angle <= a;
        @(posedge clk);
        while (!operand_ch.ready)
            @(posedge clk);
        expected_sines.push_back(sine_series(a));
        burst_left--;
    endtask

    // Drop valid and wait until every expected result is out.
    task automatic drain_results;
        operand_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_sines.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_angles;
        logic [31:0] angles[$];
        angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd256, -32'sd256,
                   HALF_PI_Q29, -HALF_PI_Q29, HALF_PI_Q29 - 32'd1, HALF_PI_Q29 + 32'd1,
                   PI_Q29, -PI_Q29, PI_Q29 - 32'd1, -(PI_Q29 - 32'd1),
                   PI_Q29 + 32'd1, -(PI_Q29 + 32'd1),
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'd536870912, -32'sd536870912};
        foreach (angles[i])
            send_angle(angles[i]);
        drain_results();
    endtask

    task automatic test_random_in_range(input int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = $urandom_range(0, 2 * PI_Q29) - PI_Q29;
            send_angle(a);
        end
        drain_results();
    endtask

    task automatic test_random_full_range(input int count);
        for (int i = 0; i < count; i++)
            send_angle($urandom());
        drain_results();
    endtask

    task automatic test_random_near_peaks(input int count);
        logic [31:0] base;
        int          off;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 4))
                0: base = HALF_PI_Q29;
                1: base = -HALF_PI_Q29;
                2: base = PI_Q29;
                3: base = -PI_Q29;
                default: base = 32'd0;
            endcase
            off = int'($urandom_range(0, 2000000)) - 1000000;
            send_angle(base + 32'(off));
        end
        drain_results();
    endtask

    // Check each result item and drive the receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_sines.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected sine item: actual %0d", result_ch.sine);
                end
                else if (result_ch.sine !== expected_sines[0])
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("sine mismatch: expected %0d actual %0d",
                                 expected_sines[0], result_ch.sine);
                    void'(expected_sines.pop_front());
                end
                else
                    void'(expected_sines.pop_front());
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
            end
            else
                stall_left--;
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        rst_n = 1'b0;
        operand_ch.valid = 1'b0;
        operand_ch.angle = '0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_angles();
        test_random_in_range(450);
        test_random_near_peaks(180);
        test_random_full_range(170);

        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (expected_sines.size() != 0)
        begin
            error_count += expected_sines.size();
            $display("%0d sine items never arrived", expected_sines.size());
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: taylor_sine_term_recurrence.f
rtl/tsr_pkg.sv
rtl/tsr_angle_if.sv
rtl/tsr_sine_if.sv
rtl/tsr_front.sv
rtl/tsr_cell.sv
rtl/tsr_tail.sv
rtl/taylor_sine_term_recurrence.sv
verif/tb_taylor_sine_term_recurrence.sv
